// ===== hw/rtl/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int VALUE_BITS    = 16;
   localparam int PRIORITY_BITS = 8;
   localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      op_type                     operation;
      logic [VALUE_BITS-1:0]      item_value;
      logic [PRIORITY_BITS-1:0]   item_priority;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic [VALUE_BITS-1:0]      head_value;
      logic [PRIORITY_BITS-1:0]   head_priority;
      logic [COUNT_BITS-1:0]      occupancy;
   } rsp_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0]      value;
      logic [PRIORITY_BITS-1:0]   prio;
   } entry_type;

   typedef struct packed {
      logic                       insert;
      logic                       remove;
      entry_type                  new_entry;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/sorted_priority_queue_core.sv =====
`timescale 1ns / 1ps

// The result word appears on rsp_word with rsp_strobe in the cycle after start is taken.
// Throughput: one insert or remove per cycle while busy is low; every cell compares and shifts in that cycle.
// The receiver cannot stall, so rsp_strobe is shown for exactly one cycle per result.
// Reset (synchronous, active high) empties the queue; busy is registered high under reset
// and clears once reset is released. Entries hold no reset value and are read only below the count.
module sorted_priority_queue_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spq_pkg::req_type req_word,
   output logic             rsp_strobe,
   output spq_pkg::rsp_type rsp_word
);

   logic                              busy_ff;
   logic [spq_pkg::COUNT_BITS-1:0]    count_ff;
   logic [spq_pkg::COUNT_BITS-1:0]    count_in;
   logic                              rsp_strobe_ff;
   spq_pkg::rsp_type                  rsp_word_ff;
   spq_pkg::rsp_type                  rsp_word_in;
   spq_pkg::cell_ctrl_type            ctrl;
   spq_pkg::entry_type                cell_entry [spq_pkg::QUEUE_DEPTH];
   logic [spq_pkg::QUEUE_DEPTH-1:0]   cell_behind;
   logic                              accept;
   logic                              full;
   logic                              empty;

   assign accept = start && !busy_ff;
   assign full   = (count_ff == spq_pkg::COUNT_BITS'(spq_pkg::QUEUE_DEPTH));
   assign empty  = (count_ff == '0);

   always_comb begin
      ctrl.insert             = accept && (req_word.operation == spq_pkg::OP_INSERT) && !full;
      ctrl.remove             = accept && (req_word.operation == spq_pkg::OP_REMOVE) && !empty;
      ctrl.new_entry.value    = req_word.item_value;
      ctrl.new_entry.prio     = req_word.item_priority;
   end

   genvar i;
   generate
      for (i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin : gen_cell
         logic               left_behind;
         spq_pkg::entry_type left_entry;
         spq_pkg::entry_type right_entry;

         if (i == 0) begin : gen_head
            assign left_behind = 1'b1;
            assign left_entry  = ctrl.new_entry;
         end else begin : gen_body
            assign left_behind = cell_behind[i-1];
            assign left_entry  = cell_entry[i-1];
         end

         if (i == spq_pkg::QUEUE_DEPTH - 1) begin : gen_tail
            assign right_entry = cell_entry[i];
         end else begin : gen_inner
            assign right_entry = cell_entry[i+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occupied    (spq_pkg::COUNT_BITS'(i) < count_ff),
            .left_behind (left_behind),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .behind      (cell_behind[i]),
            .entry       (cell_entry[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + spq_pkg::COUNT_BITS'(1);
      end else if (ctrl.remove) begin
         count_in = count_ff - spq_pkg::COUNT_BITS'(1);
      end

      rsp_word_in.status        = spq_pkg::ST_DONE;
      rsp_word_in.head_value    = '0;
      rsp_word_in.head_priority = '0;
      rsp_word_in.occupancy     = count_in;
      case (req_word.operation)
         spq_pkg::OP_INSERT: begin
            if (full) begin
               rsp_word_in.status = spq_pkg::ST_FULL;
            end
         end
         spq_pkg::OP_REMOVE: begin
            if (empty) begin
               rsp_word_in.status = spq_pkg::ST_EMPTY;
            end else begin
               rsp_word_in.head_value    = cell_entry[0].value;
               rsp_word_in.head_priority = cell_entry[0].prio;
            end
         end
         default: begin
            rsp_word_in.status = spq_pkg::ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

// ===== hw/rtl/spq_cell.sv =====
`timescale 1ns / 1ps

module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                  occupied,
   input  logic                  left_behind,
   input  spq_pkg::entry_type    left_entry,
   input  spq_pkg::entry_type    right_entry,
   output logic                  behind,
   output spq_pkg::entry_type    entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // The new word goes behind this cell when the cell holds an entry whose
   // priority is at least as large as the new one.
   assign behind = occupied && (entry_ff.prio >= ctrl.new_entry.prio);
   assign entry  = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert && !behind) begin
         entry_in = left_behind ? ctrl.new_entry : left_entry;
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hw/rtl/spq_checker.sv =====
`timescale 1ns / 1ps

module spq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input spq_pkg::rsp_type rsp_word
);

   // Every accepted word gives exactly one result in the next cycle.
   assert property (@(posedge clock) disable iff (reset || $past(reset))
      rsp_strobe == $past(start && !busy))
      else $error("result strobe does not follow an accepted word");

   // A dropped insert is reported only when the queue is full.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status == spq_pkg::ST_FULL) |->
         (rsp_word.occupancy == spq_pkg::COUNT_BITS'(spq_pkg::QUEUE_DEPTH)
          && rsp_word.head_value == '0 && rsp_word.head_priority == '0))
      else $error("full status with wrong occupancy or head");

   // A remove on an empty queue leaves it empty and returns zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status == spq_pkg::ST_EMPTY) |->
         (rsp_word.occupancy == '0 && rsp_word.head_value == '0
          && rsp_word.head_priority == '0))
      else $error("empty status with wrong occupancy or head");

   // Occupancy never exceeds the queue depth.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         (rsp_word.occupancy <= spq_pkg::COUNT_BITS'(spq_pkg::QUEUE_DEPTH)))
      else $error("occupancy beyond queue depth");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);
